### src/bsc_pkg.sv
// Shared constants, types and register codes for the bright spot centroid block.
// Used by every module under src; depends on nothing.
package bsc_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
   localparam int PIX_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int SUMX_W  = COL_W + PIX_W;
   localparam int SUMY_W  = ROW_W + PIX_W;
   localparam int SUM_W   = (SUMX_W > SUMY_W) ? SUMX_W : SUMY_W;
   localparam int FRAC_W  = 4;
   localparam int DVD_W   = SUM_W + FRAC_W;
   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int QUO_W   = $clog2(MAX_DIM * (2 ** FRAC_W));
   localparam int STEP_W  = $clog2(QUO_W);

   localparam int CENT_W      = 15;
   localparam int COUNT_OUT_W = 23;
   localparam int COLOR_W     = 8;
   localparam int THR_W       = 8;
   localparam int SIZE_W      = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;

   localparam int WEIGHT_W   = 16;
   localparam int PROD_W     = COLOR_W + WEIGHT_W;
   localparam int GSUM_W     = PROD_W + 2;
   localparam int GRAY_SHIFT = 16;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = 16'd19595;
   localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 16'd38469;
   localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = 16'd7472;

   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 8'd125;
   localparam logic [SIZE_W-1:0] WIDTH_RESET     = 12'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET    = 12'd480;

   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [THR_W-1:0]  gray_threshold;
      logic [SIZE_W-1:0] frame_width;
      logic [SIZE_W-1:0] frame_height;
   } csr_type;

   typedef struct packed {
      logic [SUMX_W-1:0] sum_x;
      logic [SUMY_W-1:0] sum_y;
      logic [PIX_W-1:0]  count;
   } frame_sums_type;

endpackage

### src/bsc_front.sv
// Pixel front end: gray conversion, threshold, raster counters and frame sums.
// Pushes one set of frame totals per frame. Depends on bsc_pkg.
module bsc_front
   import bsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  csr_type              csr,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [COLOR_W-1:0]   req_red,
   input  logic [COLOR_W-1:0]   req_green,
   input  logic [COLOR_W-1:0]   req_blue,
   output logic                 push_valid,
   input  logic                 push_ready,
   output frame_sums_type       push_data
);

   function automatic logic [WDIM_W-1:0] clamp_width(input logic [SIZE_W-1:0] v);
      logic [WDIM_W-1:0] r;
      if (v == '0) begin
         r = WDIM_W'(1);
      end else if (32'(v) > MAX_WIDTH) begin
         r = WDIM_W'(MAX_WIDTH);
      end else begin
         r = WDIM_W'(v);
      end
      return r;
   endfunction

   function automatic logic [HDIM_W-1:0] clamp_height(input logic [SIZE_W-1:0] v);
      logic [HDIM_W-1:0] r;
      if (v == '0) begin
         r = HDIM_W'(1);
      end else if (32'(v) > MAX_HEIGHT) begin
         r = HDIM_W'(MAX_HEIGHT);
      end else begin
         r = HDIM_W'(v);
      end
      return r;
   endfunction

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              p_vld_ff, p_vld_in;
   logic              p_last_ff, p_last_in;
   logic [COL_W-1:0]  p_col_ff, p_col_in;
   logic [ROW_W-1:0]  p_row_ff, p_row_in;
   logic [PROD_W-1:0] prod_r_ff, prod_r_in;
   logic [PROD_W-1:0] prod_g_ff, prod_g_in;
   logic [PROD_W-1:0] prod_b_ff, prod_b_in;
   logic [SUMX_W-1:0] sum_x_ff, sum_x_in;
   logic [SUMY_W-1:0] sum_y_ff, sum_y_in;
   logic [PIX_W-1:0]  cnt_ff, cnt_in;

   logic [WDIM_W-1:0]  w_use;
   logic [HDIM_W-1:0]  h_use;
   logic               col_end, row_end, accept, advance, bright;
   logic [GSUM_W-1:0]  gray_sum;
   logic [COLOR_W-1:0] gray;
   logic [SUMX_W-1:0]  sx_next;
   logic [SUMY_W-1:0]  sy_next;
   logic [PIX_W-1:0]   cnt_next;

   always_comb begin
      w_use   = clamp_width(csr.frame_width);
      h_use   = clamp_height(csr.frame_height);
      col_end = (WDIM_W'(col_ff) + WDIM_W'(1)) >= w_use;
      row_end = (HDIM_W'(row_ff) + HDIM_W'(1)) >= h_use;

      advance   = p_vld_ff & (~p_last_ff | push_ready);
      req_ready = ~p_vld_ff | advance;
      accept    = req_valid & req_ready;

      gray_sum = GSUM_W'(prod_r_ff) + GSUM_W'(prod_g_ff) + GSUM_W'(prod_b_ff);
      gray     = COLOR_W'(gray_sum >> GRAY_SHIFT);
      bright   = gray > csr.gray_threshold;
      sx_next  = sum_x_ff + (bright ? SUMX_W'(p_col_ff) : '0);
      sy_next  = sum_y_ff + (bright ? SUMY_W'(p_row_ff) : '0);
      cnt_next = cnt_ff + (bright ? PIX_W'(1) : '0);

      push_valid      = p_vld_ff & p_last_ff;
      push_data.sum_x = sx_next;
      push_data.sum_y = sy_next;
      push_data.count = cnt_next;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end

      p_vld_in  = accept ? 1'b1 : (advance ? 1'b0 : p_vld_ff);
      p_last_in = p_last_ff;
      p_col_in  = p_col_ff;
      p_row_in  = p_row_ff;
      prod_r_in = prod_r_ff;
      prod_g_in = prod_g_ff;
      prod_b_in = prod_b_ff;
      if (accept) begin
         p_last_in = col_end & row_end;
         p_col_in  = col_ff;
         p_row_in  = row_ff;
         prod_r_in = PROD_W'(req_red) * PROD_W'(WEIGHT_RED);
         prod_g_in = PROD_W'(req_green) * PROD_W'(WEIGHT_GREEN);
         prod_b_in = PROD_W'(req_blue) * PROD_W'(WEIGHT_BLUE);
      end

      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      cnt_in   = cnt_ff;
      if (advance) begin
         if (p_last_ff) begin
            sum_x_in = '0;
            sum_y_in = '0;
            cnt_in   = '0;
         end else begin
            sum_x_in = sx_next;
            sum_y_in = sy_next;
            cnt_in   = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         p_vld_ff <= 1'b0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         p_vld_ff <= p_vld_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      p_last_ff <= p_last_in;
      p_col_ff  <= p_col_in;
      p_row_ff  <= p_row_in;
      prod_r_ff <= prod_r_in;
      prod_g_ff <= prod_g_in;
      prod_b_ff <= prod_b_in;
   end

endmodule

### src/bsc_queue.sv
// Short queue of frame totals between the pixel front end and the divider.
// Depends on bsc_pkg.
module bsc_queue
   import bsc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_valid,
   output logic           wr_ready,
   input  frame_sums_type wr_data,
   output logic           rd_valid,
   input  logic           rd_ready,
   output frame_sums_type rd_data
);

   frame_sums_type    entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              push, pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (32'(p) == QUEUE_DEPTH - 1) begin
         r = '0;
      end else begin
         r = p + QPTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      wr_ready  = 32'(fill_ff) != QUEUE_DEPTH;
      rd_valid  = fill_ff != '0;
      rd_data   = entry_ff[rd_ptr_ff];
      push      = wr_valid & wr_ready;
      pop       = rd_valid & rd_ready;
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### src/bsc_back.sv
// Back end: one restoring divider, shared by both axes, and the result register.
// Takes frame totals from bsc_queue. Depends on bsc_pkg.
module bsc_back
   import bsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  frame_sums_type         pop_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CENT_W-1:0]      rsp_centroid_x,
   output logic [CENT_W-1:0]      rsp_centroid_y,
   output logic [COUNT_OUT_W-1:0] rsp_bright_count,
   output logic                   rsp_spot_found
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIV_X  = 4'b0010,
      ST_DIV_Y  = 4'b0100,
      ST_RESULT = 4'b1000
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PIX_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [PIX_W-1:0]  count_ff, count_in;
   logic [SUMY_W-1:0] sum_y_ff, sum_y_in;
   logic [CENT_W-1:0] cx_ff, cx_in;
   logic [CENT_W-1:0] cy_ff, cy_in;

   logic [PIX_W:0]    trial;
   logic              ge;
   logic [PIX_W-1:0]  rem_step;
   logic [QUO_W-1:0]  quo_step;
   logic              last_step;
   logic [DVD_W-1:0]  dvd_x, dvd_y;

   always_comb begin
      trial     = {rem_ff, quo_ff[QUO_W-1]};
      ge        = trial >= {1'b0, count_ff};
      rem_step  = ge ? PIX_W'(trial - {1'b0, count_ff}) : trial[PIX_W-1:0];
      quo_step  = {quo_ff[QUO_W-2:0], ge};
      last_step = step_ff == STEP_W'(QUO_W - 1);
      dvd_x     = DVD_W'(pop_data.sum_x) << FRAC_W;
      dvd_y     = DVD_W'(sum_y_ff) << FRAC_W;

      pop_ready = state_ff == ST_IDLE;
      rsp_valid = state_ff == ST_RESULT;

      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      sum_y_in = sum_y_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               count_in = pop_data.count;
               sum_y_in = pop_data.sum_y;
               rem_in   = PIX_W'(dvd_x >> QUO_W);
               quo_in   = dvd_x[QUO_W-1:0];
               step_in  = '0;
               if (pop_data.count == '0) begin
                  cx_in    = '0;
                  cy_in    = '0;
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_DIV_X;
               end
            end
         end
         ST_DIV_X: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               cx_in    = CENT_W'(quo_step);
               rem_in   = PIX_W'(dvd_y >> QUO_W);
               quo_in   = dvd_y[QUO_W-1:0];
               step_in  = '0;
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               cy_in    = CENT_W'(quo_step);
               step_in  = '0;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_centroid_x   = cx_ff;
      rsp_centroid_y   = cy_ff;
      rsp_bright_count = COUNT_OUT_W'(count_ff);
      rsp_spot_found   = count_ff != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      count_ff <= count_in;
      sum_y_ff <= sum_y_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
   end

endmodule

### src/bright_spot_centroid.sv
// Top level of the bright spot centroid block: control registers and the
// front end, queue and divider. Depends on bsc_pkg, bsc_front, bsc_queue, bsc_back.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    red, green, blue
//   rsp_      out        rsp_valid/rsp_ready    centroid_x, centroid_y, bright_count,
//                                               spot_found
//   csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// Pixels enter at one per clock except while the front end stalls; the front end is a two-stage pipeline.
// Each frame's totals wait in a two-entry queue; the shared divider loads a
// frame's totals while idle, divides for x and then for y, and holds the result
// until it is taken, so it takes new totals only after the last result is taken.
// The front end stalls only on a frame's last pixel with the queue full.
// Reset restores the register defaults and clears counters and sums.
module bright_spot_centroid
   import bsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COLOR_W-1:0]     req_red,
   input  logic [COLOR_W-1:0]     req_green,
   input  logic [COLOR_W-1:0]     req_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CENT_W-1:0]      rsp_centroid_x,
   output logic [CENT_W-1:0]      rsp_centroid_y,
   output logic [COUNT_OUT_W-1:0] rsp_bright_count,
   output logic                   rsp_spot_found,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   csr_type        csr_ff, csr_in;
   logic           push_valid, push_ready;
   frame_sums_type push_data;
   logic           pop_valid, pop_ready;
   frame_sums_type pop_data;

   always_comb begin
      csr_ready = 1'b1;
      csr_in    = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GRAY_THRESHOLD: csr_in.gray_threshold = csr_data[THR_W-1:0];
            CSR_FRAME_WIDTH:    csr_in.frame_width    = SIZE_W'(csr_data);
            CSR_FRAME_HEIGHT:   csr_in.frame_height   = SIZE_W'(csr_data);
            default: begin
               csr_in = csr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.gray_threshold <= THRESHOLD_RESET;
         csr_ff.frame_width    <= WIDTH_RESET;
         csr_ff.frame_height   <= HEIGHT_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   bsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   bsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  (push_data),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_data  (pop_data)
   );

   bsc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_centroid_x   (rsp_centroid_x),
      .rsp_centroid_y   (rsp_centroid_y),
      .rsp_bright_count (rsp_bright_count),
      .rsp_spot_found   (rsp_spot_found)
   );

endmodule
